FILE: rtl/core/tfcu_pkg.sv
package tfcu_pkg;

	// Default geometry
	localparam int SENSOR_COLS_DEF = 32;
	localparam int SENSOR_ROWS_DEF = 24;
	localparam int REPEAT_X_DEF    = 4;
	localparam int REPEAT_Y_DEF    = 4;
	localparam int OUT_COLS_DEF    = 128;
	localparam int OUT_ROWS_DEF    = 96;

	// Field widths
	localparam int TEMP_W   = 16;
	localparam int LIMIT_W  = 10;
	localparam int CHAN_W   = 8;
	localparam int OUT_X_W  = 7;
	localparam int OUT_Y_W  = 7;

	// Output positions before masking and clip limits hold up to 4095
	localparam int POS_W    = 12;
	// Block repeat counts hold 0..15
	localparam int REP_W    = 4;

	// Register map
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic [0:0] REG_LOWER = 1'b0;
	localparam logic [0:0] REG_UPPER = 1'b1;
	localparam logic [LIMIT_W-1:0] LOWER_RESET = 10'd200;
	localparam logic [LIMIT_W-1:0] UPPER_RESET = 10'd400;

	// Jet offsets for red, green, blue
	localparam logic [9:0] JET_K_RED   = 10'd765;
	localparam logic [9:0] JET_K_GREEN = 10'd510;
	localparam logic [9:0] JET_K_BLUE  = 10'd255;

	// One scaled sample handed from front to back
	typedef struct packed {
		logic [POS_W-1:0]  base_x;
		logic [POS_W-1:0]  base_y;
		logic [REP_W-1:0]  cnt_x;
		logic [REP_W-1:0]  cnt_y;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} blk_t;

	// 382 - |4*idx - k|, clamped to 0..255
	function automatic logic [CHAN_W-1:0] jet_channel(input logic [7:0] idx,
			input logic [9:0] k);
		logic signed [11:0] d;
		logic signed [11:0] v;
		logic [CHAN_W-1:0] res;
		d = $signed({2'b00, idx, 2'b00}) - $signed({2'b00, k});
		if (d < 0) begin
			d = -d;
		end
		v = 12'sd382 - d;
		if (v < 0) begin
			res = '0;
		end else if (v > 12'sd255) begin
			res = 8'd255;
		end else begin
			res = v[CHAN_W-1:0];
		end
		return res;
	endfunction

	// Number of block pixels inside the output image along one axis
	function automatic logic [REP_W-1:0] clip_count(input logic [POS_W-1:0] base,
			input logic [POS_W-1:0] limit, input logic [REP_W-1:0] rep);
		logic [POS_W-1:0] room;
		logic [REP_W-1:0] res;
		room = limit - base;
		if (base >= limit) begin
			res = '0;
		end else if (room >= {{(POS_W-REP_W){1'b0}}, rep}) begin
			res = rep;
		end else begin
			res = room[REP_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/tfcu_front.sv
module tfcu_front import tfcu_pkg::*; #(
	parameter int SENSOR_COLS = SENSOR_COLS_DEF,
	parameter int SENSOR_ROWS = SENSOR_ROWS_DEF,
	parameter int REPEAT_X    = REPEAT_X_DEF,
	parameter int REPEAT_Y    = REPEAT_Y_DEF,
	parameter int OUT_COLS    = OUT_COLS_DEF,
	parameter int OUT_ROWS    = OUT_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [LIMIT_W-1:0]        lower_limit,
	input  logic [LIMIT_W-1:0]        upper_limit,
	input  logic                      temperature_valid,
	output logic                      temperature_ready,
	input  logic signed [TEMP_W-1:0]  temperature,
	output blk_t                      blk,
	output logic                      blk_valid,
	input  logic                      blk_ready
);

	localparam int COL_W = (SENSOR_COLS > 1) ? $clog2(SENSOR_COLS) : 1;
	localparam int ROW_W = (SENSOR_ROWS > 1) ? $clog2(SENSOR_ROWS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_SAT  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	logic [2:0]               state_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [22:0]              rem_q;
	logic [22:0]              dsr_q;
	logic [13:0]              den_q;
	logic [2:0]               step_q;
	logic [7:0]               idx_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;

	logic [13:0]        lo_w;
	logic [13:0]        hi_w;
	logic signed [17:0] num_w;
	logic [22:0]        prod_w;
	logic               sat_w;
	logic               ge_w;
	logic [22:0]        rem_sub_w;
	logic [POS_W-1:0]   base_x_w;
	logic [POS_W-1:0]   base_y_w;
	logic [REP_W-1:0]   cnt_x_w;
	logic [REP_W-1:0]   cnt_y_w;
	logic               empty_w;

	assign lo_w   = ({4'd0, lower_limit} << 3) + ({4'd0, lower_limit} << 1);
	assign hi_w   = ({4'd0, upper_limit} << 3) + ({4'd0, upper_limit} << 1);
	assign num_w  = {{2{temp_q[TEMP_W-1]}}, temp_q} - $signed({4'd0, lo_w});
	// num is below 2^15 whenever it is positive
	assign prod_w = ({8'd0, num_w[14:0]} << 8) - {8'd0, num_w[14:0]};
	assign sat_w  = rem_q >= {1'b0, den_q, 8'd0};
	assign ge_w   = rem_q >= dsr_q;
	assign rem_sub_w = rem_q - dsr_q;

	assign base_x_w = POS_W'(col_q) * POS_W'(REPEAT_X);
	assign base_y_w = POS_W'(row_q) * POS_W'(REPEAT_Y);
	assign cnt_x_w  = clip_count(base_x_w, POS_W'(OUT_COLS), REP_W'(REPEAT_X));
	assign cnt_y_w  = clip_count(base_y_w, POS_W'(OUT_ROWS), REP_W'(REPEAT_Y));
	assign empty_w  = (cnt_x_w == '0) || (cnt_y_w == '0);

	assign temperature_ready = (state_q == ST_IDLE);
	assign blk_valid = (state_q == ST_PUSH) && !empty_w;

	always_comb begin
		blk.base_x = base_x_w;
		blk.base_y = base_y_w;
		blk.cnt_x  = cnt_x_w;
		blk.cnt_y  = cnt_y_w;
		blk.red    = jet_channel(idx_q, JET_K_RED);
		blk.green  = jet_channel(idx_q, JET_K_GREEN);
		blk.blue   = jet_channel(idx_q, JET_K_BLUE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (temperature_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (hi_w <= lo_w || num_w <= 0) begin
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= sat_w ? ST_PUSH : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (empty_w || blk_ready) begin
						state_q <= ST_IDLE;
						if (col_q == COL_W'(SENSOR_COLS - 1)) begin
							col_q <= '0;
							row_q <= (row_q == ROW_W'(SENSOR_ROWS - 1)) ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				temp_q <= temperature;
			end
			ST_CALC: begin
				rem_q <= prod_w;
				den_q <= hi_w - lo_w;
				if (hi_w <= lo_w) begin
					idx_q <= num_w[17] ? 8'd0 : 8'd255;
				end else begin
					idx_q <= 8'd0;
				end
			end
			ST_SAT: begin
				dsr_q  <= {2'b00, den_q, 7'd0};
				step_q <= 3'd7;
				idx_q  <= sat_w ? 8'd255 : 8'd0;
			end
			ST_DIV: begin
				if (ge_w) begin
					rem_q <= rem_sub_w;
				end
				dsr_q  <= dsr_q >> 1;
				step_q <= step_q - 1'b1;
				idx_q  <= {idx_q[6:0], ge_w};
			end
			ST_PUSH: begin
				idx_q <= idx_q;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

FILE: rtl/core/tfcu_queue.sv
module tfcu_queue import tfcu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  blk_t push_blk,
	input  logic push_valid,
	output logic push_ready,
	output blk_t pop_blk,
	output logic pop_valid,
	input  logic pop_ready
);

	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	blk_t       entry_q [2];
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_blk    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_blk;
		end
	end

endmodule

FILE: rtl/core/tfcu_back.sv
module tfcu_back import tfcu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  blk_t               blk,
	input  logic               blk_valid,
	output logic               blk_pop,
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output logic [OUT_X_W-1:0] pixel_x,
	output logic [OUT_Y_W-1:0] pixel_y,
	output logic [CHAN_W-1:0]  red,
	output logic [CHAN_W-1:0]  green,
	output logic [CHAN_W-1:0]  blue,
	output logic               block_last
);

	logic [REP_W-1:0] dx_q;
	logic [REP_W-1:0] dy_q;
	logic             valid_q;
	logic             adv_w;
	logic             fire_w;
	logic             last_x_w;
	logic             last_w;
	logic [POS_W-1:0] px_w;
	logic [POS_W-1:0] py_w;

	assign adv_w    = !valid_q || pixel_ready;
	assign fire_w   = adv_w && blk_valid;
	assign last_x_w = (dx_q == blk.cnt_x - 1'b1);
	assign last_w   = last_x_w && (dy_q == blk.cnt_y - 1'b1);
	assign blk_pop  = fire_w && last_w;
	assign px_w     = blk.base_x + POS_W'(dx_q);
	assign py_w     = blk.base_y + POS_W'(dy_q);
	assign pixel_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dx_q    <= '0;
			dy_q    <= '0;
		end else begin
			if (adv_w) begin
				valid_q <= blk_valid;
			end
			if (fire_w) begin
				if (last_x_w) begin
					dx_q <= '0;
					dy_q <= last_w ? '0 : dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_w) begin
			pixel_x    <= px_w[OUT_X_W-1:0];
			pixel_y    <= py_w[OUT_Y_W-1:0];
			red        <= blk.red;
			green      <= blk.green;
			blue       <= blk.blue;
			block_last <= last_w;
		end
	end

endmodule

FILE: rtl/core/thermal_false_color_upscaler_unit.sv
// Thermal false-color upscaler.
// Input channel (temperature_valid/ready, temperature): one signed sensor sample
// per request, hundredths of a degree, in raster order over the sensor grid.
// Output channel (pixel_valid/ready): one request per emitted output pixel with
// its column, row, jet color and a block_last flag on the last pixel of a sample.
// APB port: register 0 (address 0) lower_limit, register 1 (address 4)
// upper_limit, both in tenths of a degree, pready always high.
// Front: a sample passes accept, scale and hand-off when the index is
// settled at once, adds a clamp check when it saturates, and adds the clamp
// check and the 8-step restoring divider when the index needs division; each
// block then passes through the queue to the output register.
// The back end emits one pixel per cycle while the receiver is ready, and the
// front can scale the next sample while the back end still walks a block.
// A fully clipped block emits nothing, though the grid position still advances.
// Reset clears the grid position, the queue and the output valid, and loads
// the limits with 20.0 and 40.0 degrees.
// When the receiver stalls, the output register holds, then the two-entry queue
// fills, then the front stops taking samples.
module thermal_false_color_upscaler_unit import tfcu_pkg::*; #(
	parameter int SENSOR_COLS = SENSOR_COLS_DEF,
	parameter int SENSOR_ROWS = SENSOR_ROWS_DEF,
	parameter int REPEAT_X    = REPEAT_X_DEF,
	parameter int REPEAT_Y    = REPEAT_Y_DEF,
	parameter int OUT_COLS    = OUT_COLS_DEF,
	parameter int OUT_ROWS    = OUT_ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     temperature_valid,
	output logic                     temperature_ready,
	input  logic signed [TEMP_W-1:0] temperature,
	output logic                     pixel_valid,
	input  logic                     pixel_ready,
	output logic [OUT_X_W-1:0]       pixel_x,
	output logic [OUT_Y_W-1:0]       pixel_y,
	output logic [CHAN_W-1:0]        red,
	output logic [CHAN_W-1:0]        green,
	output logic [CHAN_W-1:0]        blue,
	output logic                     block_last
);

	logic [LIMIT_W-1:0] lower_q;
	logic [LIMIT_W-1:0] upper_q;
	logic               wr_en;
	logic [0:0]         reg_idx;

	blk_t front_blk;
	logic front_valid;
	logic front_ready;
	blk_t head_blk;
	logic head_valid;
	logic head_pop;

	// Register file: word index from paddr, byte offset ignored
	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_LOWER: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, lower_q};
			REG_UPPER: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, upper_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LOWER: lower_q <= pwdata[LIMIT_W-1:0];
				REG_UPPER: upper_q <= pwdata[LIMIT_W-1:0];
				default:   lower_q <= lower_q;
			endcase
		end
	end

	// Front: accept a sample, scale it to a color index, clip its block
	tfcu_front #(
		.SENSOR_COLS (SENSOR_COLS),
		.SENSOR_ROWS (SENSOR_ROWS),
		.REPEAT_X    (REPEAT_X),
		.REPEAT_Y    (REPEAT_Y),
		.OUT_COLS    (OUT_COLS),
		.OUT_ROWS    (OUT_ROWS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.lower_limit       (lower_q),
		.upper_limit       (upper_q),
		.temperature_valid (temperature_valid),
		.temperature_ready (temperature_ready),
		.temperature       (temperature),
		.blk               (front_blk),
		.blk_valid         (front_valid),
		.blk_ready         (front_ready)
	);

	// Queue: decouple scaling from pixel emission
	tfcu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_blk   (front_blk),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_blk    (head_blk),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop)
	);

	// Back: walk the visible part of each block, one pixel per cycle while pixel_ready is high
	tfcu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk         (head_blk),
		.blk_valid   (head_valid),
		.blk_pop     (head_pop),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.block_last  (block_last)
	);

endmodule

FILE: tb/tb_thermal_false_color_upscaler_unit.sv
`timescale 1ns / 1ps

module tb_thermal_false_color_upscaler_unit import tfcu_pkg::*;;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_MIN    = 105;
	localparam int PHASE_SAMPLES = 35;
	// Long enough for the output register, the queue and the front to fill.
	localparam int LONG_HOLD     = 400;
	// Pad for the front and the output register to settle.
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int REPORT_CAP    = 200;

	// One output pixel as the block should present it
	typedef struct packed {
		logic [OUT_X_W-1:0] x;
		logic [OUT_Y_W-1:0] y;
		logic [CHAN_W-1:0]  r;
		logic [CHAN_W-1:0]  g;
		logic [CHAN_W-1:0]  b;
		logic               last;
	} pixel_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     temperature_valid = 1'b0;
	logic                     temperature_ready;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic                     pixel_valid;
	logic                     pixel_ready = 1'b0;
	logic [OUT_X_W-1:0]       pixel_x;
	logic [OUT_Y_W-1:0]       pixel_y;
	logic [CHAN_W-1:0]        red;
	logic [CHAN_W-1:0]        green;
	logic [CHAN_W-1:0]        blue;
	logic                     block_last;

	// Samples waiting to be offered, and pixels the block still owes us
	logic signed [TEMP_W-1:0] samples_to_send[$];
	pixel_t                   expected_pixels[$];

	// Our own copy of the limits and of the grid position
	logic [LIMIT_W-1:0] lower_setting = LOWER_RESET;
	logic [LIMIT_W-1:0] upper_setting = UPPER_RESET;
	int grid_col = 0;
	int grid_row = 0;
	int frames_done = 0;

	// Flow control shared between the stimulus and the two clocked sides
	bit steady_flow = 1'b0;
	int hold_tickets = 0;
	int holds_served = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;

	int fail_count = 0;
	int samples_sent = 0;
	int pixels_checked = 0;
	int settings_used = 0;
	longint cycle_count = 0;

	thermal_false_color_upscaler_unit uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.temperature_valid (temperature_valid),
		.temperature_ready (temperature_ready),
		.temperature       (temperature),
		.pixel_valid       (pixel_valid),
		.pixel_ready       (pixel_ready),
		.pixel_x           (pixel_x),
		.pixel_y           (pixel_y),
		.red               (red),
		.green             (green),
		.blue              (blue),
		.block_last        (block_last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Count a failure; stop printing once the log would grow too long.
	task automatic report(input string msg);
		if (fail_count < REPORT_CAP) begin
			$display("%0t: %s", $time, msg);
		end else if (fail_count == REPORT_CAP) begin
			$display("%0t: further mismatches not shown", $time);
		end
		fail_count++;
	endtask

	// Mostly back-to-back, often a short gap, now and then a long one.
	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// Scale a sample between the limits (tenths of a degree) to an 8-bit index.
	function automatic logic [7:0] scale_index(input logic signed [TEMP_W-1:0] t,
			input logic [LIMIT_W-1:0] lo_lim, input logic [LIMIT_W-1:0] hi_lim);
		longint lo;
		longint hi;
		longint num;
		longint q;
		lo = longint'(lo_lim) * 10;
		hi = longint'(hi_lim) * 10;
		// Limits not increasing: a plain threshold at the lower limit
		if (hi <= lo) begin
			return (longint'(t) >= lo) ? 8'd255 : 8'd0;
		end
		num = longint'(t) - lo;
		if (num <= 0) begin
			return 8'd0;
		end
		q = (num * 255) / (hi - lo);
		if (q > 255) begin
			q = 255;
		end
		return q[7:0];
	endfunction

	// Jet ramp: 382 - |4*idx - k|, clamped to a channel
	function automatic logic [CHAN_W-1:0] jet_level(input logic [7:0] idx, input int k);
		int d;
		int v;
		d = int'(idx) * 4 - k;
		if (d < 0) begin
			d = -d;
		end
		v = 382 - d;
		if (v < 0) begin
			v = 0;
		end else if (v > 255) begin
			v = 255;
		end
		return v[CHAN_W-1:0];
	endfunction

	// Queue the pixels one accepted sample must produce, then advance the grid.
	task automatic predict_block(input logic signed [TEMP_W-1:0] t);
		logic [7:0] idx;
		pixel_t     px;
		int         emitted;
		int         col_px;
		int         row_px;
		int         dx;
		int         dy;
		idx = scale_index(t, lower_setting, upper_setting);
		px.r = jet_level(idx, int'(JET_K_RED));
		px.g = jet_level(idx, int'(JET_K_GREEN));
		px.b = jet_level(idx, int'(JET_K_BLUE));
		px.last = 1'b0;
		emitted = 0;
		for (dy = 0; dy < REPEAT_Y_DEF; dy++) begin
			for (dx = 0; dx < REPEAT_X_DEF; dx++) begin
				row_px = grid_row * REPEAT_Y_DEF + dy;
				col_px = grid_col * REPEAT_X_DEF + dx;
				// Drop pixels that fall off the output image
				if (col_px < OUT_COLS_DEF && row_px < OUT_ROWS_DEF) begin
					px.x = col_px[OUT_X_W-1:0];
					px.y = row_px[OUT_Y_W-1:0];
					expected_pixels.push_back(px);
					emitted++;
				end
			end
		end
		// Flag the last pixel actually emitted for this sample
		if (emitted > 0) begin
			px = expected_pixels.pop_back();
			px.last = 1'b1;
			expected_pixels.push_back(px);
		end
		grid_col++;
		if (grid_col >= SENSOR_COLS_DEF) begin
			grid_col = 0;
			grid_row++;
			if (grid_row >= SENSOR_ROWS_DEF) begin
				grid_row = 0;
				frames_done++;
			end
		end
	endtask

	task automatic compare_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			report($sformatf("%s mismatch, expected %0d, actual %0d", what, want, got));
		end
	endtask

	// Match the pixel on the port against the oldest one still owed.
	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report($sformatf("pixel (%0d,%0d) arrived with none expected, expected none, actual 1",
				pixel_x, pixel_y));
		end else begin
			want = expected_pixels.pop_front();
			compare_field("pixel_x", 8'(want.x), 8'(pixel_x));
			compare_field("pixel_y", 8'(want.y), 8'(pixel_y));
			compare_field("red", want.r, red);
			compare_field("green", want.g, green);
			compare_field("blue", want.b, blue);
			compare_field("block_last", 8'(want.last), 8'(block_last));
			pixels_checked++;
		end
	endtask

	// Sample driver: hold each request until taken, then idle for the drawn gap
	// before popping the next sample.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temperature_valid <= 1'b0;
			temperature <= '0;
			send_gap <= 0;
		end else begin
			if (temperature_valid && temperature_ready) begin
				predict_block(temperature);
				samples_sent++;
			end
			// A request still waiting keeps valid and payload as they are
			if (!temperature_valid || temperature_ready) begin
				if (send_gap > 0) begin
					temperature_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (samples_to_send.size() > 0) begin
					temperature_valid <= 1'b1;
					temperature <= samples_to_send.pop_front();
					send_gap <= steady_flow ? 0 : draw_gap();
				end else begin
					temperature_valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: check every accepted request, and throttle ready with
	// random gaps or a long hold when the stimulus asks for one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				check_pixel();
			end
			if (hold_left > 0) begin
				pixel_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (holds_served != hold_tickets) begin
				// Start a long hold so the block backs up into its input
				pixel_ready <= 1'b0;
				hold_left <= LONG_HOLD;
				holds_served <= holds_served + 1;
			end else if (recv_gap > 0) begin
				pixel_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				pixel_ready <= 1'b1;
				if (pixel_valid && pixel_ready && !steady_flow) begin
					recv_gap <= draw_gap();
				end
			end
		end
	end

	// Watchdog: stop a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		// Take read data at the edge that closes the access cycle
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_back_limits();
		logic [PDATA_W-1:0] got;
		apb_read({REG_LOWER, 2'b00}, got);
		if (got !== PDATA_W'(lower_setting)) begin
			report($sformatf("lower_limit read, expected %0d, actual %0d", lower_setting, got));
		end
		apb_read({REG_UPPER, 2'b00}, got);
		if (got !== PDATA_W'(upper_setting)) begin
			report($sformatf("upper_limit read, expected %0d, actual %0d", upper_setting, got));
		end
	endtask

	// Only called while the block is drained.
	task automatic set_limits(input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi);
		apb_write({REG_LOWER, 2'b00}, PDATA_W'(lo));
		apb_write({REG_UPPER, 2'b00}, PDATA_W'(hi));
		lower_setting = lo;
		upper_setting = hi;
		settings_used++;
		read_back_limits();
	endtask

	// Random limits: reset values, full span, equal, reversed, one step apart,
	// or an ordinary window.
	task automatic pick_limits();
		logic [LIMIT_W-1:0] lo;
		logic [LIMIT_W-1:0] hi;
		case ($urandom_range(0, 7))
			0: begin
				lo = LOWER_RESET;
				hi = UPPER_RESET;
			end
			1: begin
				lo = '0;
				hi = '1;
			end
			2: begin
				lo = LIMIT_W'($urandom_range(0, 1023));
				hi = lo;
			end
			3: begin
				hi = LIMIT_W'($urandom_range(0, 1022));
				lo = LIMIT_W'($urandom_range(int'(hi) + 1, 1023));
			end
			4: begin
				lo = LIMIT_W'($urandom_range(0, 1022));
				hi = lo + 1'b1;
			end
			default: begin
				lo = LIMIT_W'($urandom_range(0, 900));
				hi = LIMIT_W'($urandom_range(int'(lo) + 1, 1000));
			end
		endcase
		set_limits(lo, hi);
	endtask

	// Mostly around the active window, some over the sensor range, some any code.
	function automatic logic signed [TEMP_W-1:0] pick_temperature();
		int lo10;
		int hi10;
		int span_lo;
		int span_hi;
		int roll;
		lo10 = 10 * int'(lower_setting);
		hi10 = 10 * int'(upper_setting);
		span_lo = ((lo10 < hi10) ? lo10 : hi10) - 300;
		span_hi = ((lo10 < hi10) ? hi10 : lo10) + 300;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return TEMP_W'(span_lo + int'($urandom_range(0, span_hi - span_lo)));
		end else if (roll < 85) begin
			return TEMP_W'(-4000 + int'($urandom_range(0, 34000)));
		end
		return TEMP_W'($urandom());
	endfunction

	// Wait until every sample is taken and every pixel is in, then let the
	// pipeline settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (samples_to_send.size() != 0 || temperature_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		// Reset limits (20.0 to 40.0 degrees): field extremes, both sides of
		// each limit, the first index step, and alternating bit patterns.
		int probe_reset[16] = '{-32768, 32767, -4000, 30000, 0, 1999, 2000, 2001,
			2008, 2502, 3000, 3999, 4000, 4001, 21845, -21846};
		// Full register span
		int probe_full[5] = '{-1, 0, 5115, 10229, 10230};
		// Equal limits and reversed limits: threshold at the lower limit
		int probe_equal[2] = '{4999, 5000};
		int probe_reversed[2] = '{10229, 10230};
		int random_count;
		int phase;

		random_count = 0;
		phase = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		read_back_limits();

		@(negedge clk);
		foreach (probe_reset[i]) samples_to_send.push_back(TEMP_W'(probe_reset[i]));
		wait_drained();

		set_limits('0, '1);
		@(negedge clk);
		foreach (probe_full[i]) samples_to_send.push_back(TEMP_W'(probe_full[i]));
		wait_drained();

		set_limits(10'd500, 10'd500);
		@(negedge clk);
		foreach (probe_equal[i]) samples_to_send.push_back(TEMP_W'(probe_equal[i]));
		wait_drained();

		set_limits('1, '0);
		@(negedge clk);
		foreach (probe_reversed[i]) samples_to_send.push_back(TEMP_W'(probe_reversed[i]));
		wait_drained();

		// Random phases, each under new limits.
		while (random_count < RANDOM_MIN) begin
			pick_limits();
			@(negedge clk);
			steady_flow = (phase % 4 == 2);
			repeat (PHASE_SAMPLES) samples_to_send.push_back(pick_temperature());
			random_count += PHASE_SAMPLES;
			// Stall the output while the sender keeps offering
			if (phase % 6 == 0) begin
				hold_tickets++;
			end
			wait_drained();
			phase++;
		end
		steady_flow = 1'b0;

		$display("Checked %0d pixels from %0d samples under %0d limit settings, %0d frame wrap(s).",
			pixels_checked, samples_sent, settings_used, frames_done);
		$display("Run included equal, reversed and full-span limits and long output stalls.");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
